>>> hw/rtl/frame_sequence_reorder_unit_macros.svh
// Assertion macros used by the frame sequence reorder unit controller.
`ifndef FRAME_SEQUENCE_REORDER_UNIT_MACROS_SVH
`define FRAME_SEQUENCE_REORDER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define FSR_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define FSR_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/fsr_pkg.sv
// Package with widths, types and sequencer states of the frame sequence reorder unit.
package fsr_pkg;

  localparam int FSR_DEPTH    = 16;
  localparam int FSR_TAG_W    = 8;
  localparam int FSR_HANDLE_W = 16;
  localparam int FSR_WC_W     = 4;
  localparam logic [FSR_WC_W-1:0] FSR_WC_RESET = 4'd4;

  // Kind of one result.
  typedef enum logic {
    EV_RELEASE = 1'b0,
    EV_SKIP    = 1'b1
  } fsr_kind_t;

  // One stored frame.
  typedef struct packed {
    logic [FSR_TAG_W-1:0]    tag;
    logic [FSR_HANDLE_W-1:0] handle;
  } fsr_entry_t;

  // One result before its end-of-run marker is known.
  typedef struct packed {
    fsr_kind_t  kind;
    fsr_entry_t ent;
  } fsr_event_t;

  // One result as presented on the output channel.
  typedef struct packed {
    fsr_event_t ev;
    logic       last;
  } fsr_result_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FLUSH_RD,
    ST_FLUSH_EMIT,
    ST_DECIDE,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_FINISH
  } fsr_state_t;

endpackage

>>> hw/rtl/fsr_if.sv
// Valid/ready channel interfaces for input frames and results.
interface fsr_in_if
  import fsr_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic [FSR_TAG_W-1:0]    frame_tag;
  logic                    resequence;
  logic [FSR_HANDLE_W-1:0] frame_handle;

  modport source (output valid, frame_tag, resequence, frame_handle, input ready);
  modport sink   (input valid, frame_tag, resequence, frame_handle, output ready);
endinterface

interface fsr_out_if
  import fsr_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic                    event_kind;
  logic [FSR_TAG_W-1:0]    out_tag;
  logic [FSR_HANDLE_W-1:0] out_handle;
  logic                    last_of_run;

  modport source (output valid, event_kind, out_tag, out_handle, last_of_run, input ready);
  modport sink   (input valid, event_kind, out_tag, out_handle, last_of_run, output ready);
endinterface

>>> hw/rtl/fsr_store.sv
// Pending frame store: one write port and one read port with registered read data.
module fsr_store
  import fsr_pkg::*;
#(
  parameter int DEPTH = FSR_DEPTH,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  fsr_entry_t       wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output fsr_entry_t       rd_data
);

  fsr_entry_t mem_r [DEPTH];
  fsr_entry_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hw/rtl/fsr_ctrl.sv
// Sequencer that flushes, stores, releases and chains frames through the pending store.
module fsr_ctrl
  import fsr_pkg::*;
#(
  parameter int DEPTH = FSR_DEPTH,
  localparam int IDX_W = $clog2(DEPTH),
  localparam int CNT_W = $clog2(DEPTH + 1),
  localparam int CMP_W = ((CNT_W > FSR_WC_W) ? CNT_W : FSR_WC_W) + 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [FSR_WC_W-1:0] worker_count,
  fsr_in_if.sink              in_ch,
  fsr_out_if.source           out_ch,
  output logic                st_wr_en,
  output logic [IDX_W-1:0]    st_wr_addr,
  output fsr_entry_t          st_wr_data,
  output logic                st_rd_en,
  output logic [IDX_W-1:0]    st_rd_addr,
  input  fsr_entry_t          st_rd_data
);

  fsr_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     idx_r, idx_nxt;
  logic [FSR_TAG_W-1:0] exp_r, exp_nxt;
  fsr_entry_t           cur_r, cur_nxt;
  fsr_event_t           hold_r, hold_nxt;
  logic                 hold_valid_r, hold_valid_nxt;
  fsr_result_t          out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 out_free;
  logic [FSR_TAG_W-1:0] want;
  logic [CNT_W-1:0]     idx_inc;
  logic [CNT_W-1:0]     idx_inc2;
  logic                 over_limit;
  logic                 do_flush;
  logic                 emit_req;
  fsr_event_t           emit_val;
  logic                 finish_req;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign want       = exp_r + FSR_TAG_W'(1);
  assign idx_inc    = idx_r + CNT_W'(1);
  assign idx_inc2   = idx_r + CNT_W'(2);
  assign over_limit = CMP_W'(count_r) > (CMP_W'(worker_count) + CMP_W'(1));
  assign do_flush   = in_ch.resequence || over_limit || (count_r == CNT_W'(DEPTH));

  // Next state, store accesses and result generation.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    exp_nxt        = exp_r;
    cur_nxt        = cur_r;
    hold_nxt       = hold_r;
    hold_valid_nxt = hold_valid_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    in_ch.ready    = 1'b0;
    st_wr_en       = 1'b0;
    st_wr_addr     = idx_r[IDX_W-1:0];
    st_wr_data     = st_rd_data;
    st_rd_en       = 1'b0;
    st_rd_addr     = idx_r[IDX_W-1:0];
    emit_req       = 1'b0;
    emit_val       = '{kind: EV_RELEASE, ent: cur_r};
    finish_req     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cur_nxt = '{tag: in_ch.frame_tag, handle: in_ch.frame_handle};
          if (do_flush) begin
            if (count_r == '0) begin
              exp_nxt   = in_ch.frame_tag - FSR_TAG_W'(1);
              state_nxt = ST_DECIDE;
            end else begin
              idx_nxt   = '0;
              state_nxt = ST_FLUSH_RD;
            end
          end else begin
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_FLUSH_RD: begin
        st_rd_en  = 1'b1;
        state_nxt = ST_FLUSH_EMIT;
      end
      ST_FLUSH_EMIT: begin
        if (out_free) begin
          emit_req = 1'b1;
          emit_val = '{kind: EV_SKIP, ent: st_rd_data};
          if (idx_inc == count_r) begin
            count_nxt = '0;
            exp_nxt   = cur_r.tag - FSR_TAG_W'(1);
            state_nxt = ST_DECIDE;
          end else begin
            idx_nxt   = idx_inc;
            state_nxt = ST_FLUSH_RD;
          end
        end
      end
      ST_DECIDE: begin
        if (cur_r.tag != want) begin
          // Out of order: append to the store.
          st_wr_en   = 1'b1;
          st_wr_addr = count_r[IDX_W-1:0];
          st_wr_data = cur_r;
          count_nxt  = count_r + CNT_W'(1);
          state_nxt  = ST_IDLE;
        end else if (out_free) begin
          emit_req  = 1'b1;
          emit_val  = '{kind: EV_RELEASE, ent: cur_r};
          exp_nxt   = cur_r.tag;
          idx_nxt   = '0;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (idx_r >= count_r) begin
          state_nxt = ST_FINISH;
        end else begin
          st_rd_en  = 1'b1;
          state_nxt = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        if (st_rd_data.tag == want) begin
          if (out_free) begin
            emit_req = 1'b1;
            emit_val = '{kind: EV_RELEASE, ent: st_rd_data};
            exp_nxt  = want;
            if (idx_inc < count_r) begin
              state_nxt = ST_SHIFT_RD;
            end else begin
              count_nxt = count_r - CNT_W'(1);
              idx_nxt   = '0;
              state_nxt = ST_SCAN_RD;
            end
          end
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_SHIFT_RD: begin
        // Close the gap: move the next entry down by one slot.
        st_rd_en   = 1'b1;
        st_rd_addr = idx_inc[IDX_W-1:0];
        state_nxt  = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        st_wr_en = 1'b1;
        if (idx_inc2 < count_r) begin
          idx_nxt   = idx_inc;
          state_nxt = ST_SHIFT_RD;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          idx_nxt   = '0;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_FINISH: begin
        if (!hold_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          finish_req = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // A result waits in the hold register until the next one shows it was not the last.
    if (emit_req) begin
      if (hold_valid_r) begin
        out_nxt       = '{ev: hold_r, last: 1'b0};
        out_valid_nxt = 1'b1;
      end
      hold_nxt       = emit_val;
      hold_valid_nxt = 1'b1;
    end
    if (finish_req) begin
      out_nxt        = '{ev: hold_r, last: 1'b1};
      out_valid_nxt  = 1'b1;
      hold_valid_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      idx_r        <= '0;
      exp_r        <= '1;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      idx_r        <= idx_nxt;
      exp_r        <= exp_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    hold_r <= hold_nxt;
    out_r  <= out_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_kind  = out_r.ev.kind;
  assign out_ch.out_tag     = out_r.ev.ent.tag;
  assign out_ch.out_handle  = out_r.ev.ent.handle;
  assign out_ch.last_of_run = out_r.last;

`include "frame_sequence_reorder_unit_macros.svh"

  `FSR_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "pending count above depth")
  `FSR_ASSERT_NXT(a_busy_after_in, in_ch.valid && in_ch.ready, state_r != ST_IDLE, "idle after a transfer")
  `FSR_ASSERT_IMP(a_chain_held, state_r == ST_SCAN_RD || state_r == ST_SCAN_CHK, hold_valid_r, "chain scan without a held release")
  `FSR_ASSERT_IMP(a_flush_nonempty, state_r == ST_FLUSH_EMIT, count_r != '0, "flush of an empty store")

endmodule

>>> hw/rtl/frame_sequence_reorder_unit.sv
// Steps: a frame is taken in IDLE, then, after any flush, DECIDE stores it or releases it; a released
// frame passes through the hold and output registers. Each skipped entry is read, then emitted; a chain
// search reads and checks stored entries in turn, and removing a released entry moves each later entry down.
// Throughput: one frame at a time; input ready only while the sequencer is idle.
// Reset (rst_n, synchronous, active low): store empty, tag 0 expected, worker count 4.
// Store contents are not cleared; no clearing pass is needed.
module frame_sequence_reorder_unit
  import fsr_pkg::*;
#(
  parameter int PENDING_DEPTH = FSR_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  fsr_in_if.sink              in_ch,
  fsr_out_if.source           out_ch,
  input  logic                cfg_wr_en,
  input  logic [FSR_WC_W-1:0] cfg_wr_data
);

  localparam int IDX_W = $clog2(PENDING_DEPTH);

  logic [FSR_WC_W-1:0] worker_count_r;
  logic                st_wr_en;
  logic [IDX_W-1:0]    st_wr_addr;
  fsr_entry_t          st_wr_data;
  logic                st_rd_en;
  logic [IDX_W-1:0]    st_rd_addr;
  fsr_entry_t          st_rd_data;

  // Worker count register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      worker_count_r <= FSR_WC_RESET;
    end else if (cfg_wr_en) begin
      worker_count_r <= cfg_wr_data;
    end
  end

  fsr_ctrl #(
    .DEPTH(PENDING_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .worker_count(worker_count_r),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .st_wr_en    (st_wr_en),
    .st_wr_addr  (st_wr_addr),
    .st_wr_data  (st_wr_data),
    .st_rd_en    (st_rd_en),
    .st_rd_addr  (st_rd_addr),
    .st_rd_data  (st_rd_data)
  );

  fsr_store #(
    .DEPTH(PENDING_DEPTH)
  ) u_store (
    .clk    (clk),
    .wr_en  (st_wr_en),
    .wr_addr(st_wr_addr),
    .wr_data(st_wr_data),
    .rd_en  (st_rd_en),
    .rd_addr(st_rd_addr),
    .rd_data(st_rd_data)
  );

endmodule

>>> tb/sv/frame_sequence_reorder_unit_tb.sv
// Testbench for the frame sequence reorder unit: directed table plus random frame runs, checked against a reorder predictor.
module frame_sequence_reorder_unit_tb;
  import fsr_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_ITEMS   = 14;
  localparam int HOLD_AFTER    = 40;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_GAP       = 13;

  // One row of the directed table; typed rows carry their own expected result.
  typedef struct {
    logic [FSR_TAG_W-1:0]    tag;
    logic                    reseq;
    logic [FSR_HANDLE_W-1:0] handle;
    bit                      typed;
    int                      n_typed;
    fsr_kind_t               kind;
    logic [FSR_TAG_W-1:0]    etag;
    logic [FSR_HANDLE_W-1:0] ehandle;
  } directed_row_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_wr_en;
  logic [FSR_WC_W-1:0] cfg_wr_data;

  fsr_in_if  in_ch ();
  fsr_out_if out_ch ();

  frame_sequence_reorder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Predictor state: last released tag, pending frames in arrival order, worker count.
  logic [FSR_TAG_W-1:0] last_seq     = 8'hFF;
  logic [FSR_WC_W-1:0]  worker_limit = FSR_WC_RESET;
  fsr_entry_t           parked_q[$];
  fsr_result_t          due_q[$];
  int unsigned          errors       = 0;
  bit                   in_steady    = 1'b0;

  logic [FSR_WC_W-1:0] phase_wc [5] = '{4'd1, 4'd14, 4'd15, 4'd0, 4'd9};

  // Directed table, run at the reset worker count of four.
  directed_row_t directed_rows [22] = '{
    // Tag zero is expected first after reset.
    '{8'd0,   1'b0, 16'h0000, 1'b1, 1, EV_RELEASE, 8'd0,   16'h0000},
    // Two frames ahead of sequence are held, then one release drains the chain.
    '{8'd3,   1'b0, 16'hFFFF, 1'b1, 0, EV_RELEASE, 8'd0,   16'h0000},
    '{8'd2,   1'b0, 16'h1234, 1'b1, 0, EV_RELEASE, 8'd0,   16'h0000},
    '{8'd1,   1'b0, 16'h5555, 1'b0, 0, EV_RELEASE, 8'd0,   16'h0000},
    '{8'd255, 1'b0, 16'hAAAA, 1'b1, 0, EV_RELEASE, 8'd0,   16'h0000},
    '{8'd4,   1'b0, 16'h00FF, 1'b1, 1, EV_RELEASE, 8'd4,   16'h00FF},
    // Duplicate tags: the earlier arrival goes out, the later one stays.
    '{8'd6,   1'b0, 16'hAAAA, 1'b1, 0, EV_RELEASE, 8'd0,   16'h0000},
    '{8'd6,   1'b0, 16'hBBBB, 1'b1, 0, EV_RELEASE, 8'd0,   16'h0000},
    '{8'd5,   1'b0, 16'h0F0F, 1'b0, 0, EV_RELEASE, 8'd0,   16'h0000},
    // Fill past the pending limit, then the next frame flushes the store.
    '{8'd10,  1'b0, 16'h0001, 1'b1, 0, EV_RELEASE, 8'd0,   16'h0000},
    '{8'd11,  1'b0, 16'h0002, 1'b1, 0, EV_RELEASE, 8'd0,   16'h0000},
    '{8'd12,  1'b0, 16'h0003, 1'b1, 0, EV_RELEASE, 8'd0,   16'h0000},
    '{8'd13,  1'b0, 16'h0004, 1'b1, 0, EV_RELEASE, 8'd0,   16'h0000},
    '{8'd20,  1'b0, 16'h8000, 1'b0, 0, EV_RELEASE, 8'd0,   16'h0000},
    // Resequence with one frame pending, then with an empty store.
    '{8'd30,  1'b0, 16'h7FFF, 1'b1, 0, EV_RELEASE, 8'd0,   16'h0000},
    '{8'd200, 1'b1, 16'hC3C3, 1'b0, 0, EV_RELEASE, 8'd0,   16'h0000},
    '{8'd77,  1'b1, 16'hFFFF, 1'b1, 1, EV_RELEASE, 8'd77,  16'hFFFF},
    // Tag wrap from 255 to 0 inside a chain.
    '{8'd254, 1'b1, 16'h1111, 1'b1, 1, EV_RELEASE, 8'd254, 16'h1111},
    '{8'd0,   1'b0, 16'h2222, 1'b1, 0, EV_RELEASE, 8'd0,   16'h0000},
    '{8'd255, 1'b0, 16'h3333, 1'b0, 0, EV_RELEASE, 8'd0,   16'h0000},
    '{8'd1,   1'b0, 16'h4444, 1'b1, 1, EV_RELEASE, 8'd1,   16'h4444},
    // Resequence back to an already released tag.
    '{8'd1,   1'b1, 16'h5A5A, 1'b1, 1, EV_RELEASE, 8'd1,   16'h5A5A}
  };

  // Works out the results of one accepted frame and updates the predictor state.
  function automatic void reorder_predict(input logic [FSR_TAG_W-1:0] tag, input logic reseq,
                                          input logic [FSR_HANDLE_W-1:0] handle,
                                          input bit publish);
    fsr_result_t          fate [2*FSR_DEPTH+1];
    int                   n;
    int                   hit;
    logic [FSR_TAG_W-1:0] want;
    n = 0;
    // A resequence request, the pending limit or a full store flushes everything as skips.
    if (reseq || parked_q.size() > int'(worker_limit) + 1 || parked_q.size() >= FSR_DEPTH) begin
      foreach (parked_q[i]) begin
        fate[n] = fsr_result_t'({EV_SKIP, parked_q[i], 1'b0});
        n++;
      end
      parked_q.delete();
      last_seq = tag - 8'd1;
    end
    want = last_seq + 8'd1;
    if (tag != want) begin
      parked_q.push_back(fsr_entry_t'({tag, handle}));
    end else begin
      fate[n] = fsr_result_t'({EV_RELEASE, tag, handle, 1'b0});
      n++;
      last_seq = tag;
      // Keep releasing the earliest pending frame that holds the next tag.
      do begin
        want = last_seq + 8'd1;
        hit = -1;
        foreach (parked_q[i]) begin
          if (hit < 0 && parked_q[i].tag == want) hit = i;
        end
        if (hit >= 0) begin
          fate[n] = fsr_result_t'({EV_RELEASE, parked_q[hit], 1'b0});
          n++;
          last_seq = want;
          parked_q.delete(hit);
        end
      end while (hit >= 0);
    end
    if (n > 0) fate[n-1].last = 1'b1;
    if (publish) begin
      for (int i = 0; i < n; i++) due_q.push_back(fate[i]);
    end
  endfunction

  // Idle cycles before the next transfer; calm stretches with no idling come and go.
  function automatic int unsigned draw_gap(inout bit steady);
    if ($urandom_range(0, 11) == 0) steady = !steady;
    return steady ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  task automatic flag_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
  endtask

  // Offers one frame until it is transferred, then predicts its results.
  task automatic send_frame(input logic [FSR_TAG_W-1:0] tag, input logic reseq,
                            input logic [FSR_HANDLE_W-1:0] handle, input bit publish);
    int unsigned gap;
    gap = draw_gap(in_steady);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.frame_tag    <= tag;
    in_ch.resequence   <= reseq;
    in_ch.frame_handle <= handle;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    reorder_predict(tag, reseq, handle, publish);
  endtask

  // Stops offering, waits for every expected result, then lets the block settle.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (due_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_worker_count(input logic [FSR_WC_W-1:0] value);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    worker_limit = value;
  endtask

  // Result side: random stalls, one long hold-off, and the field-by-field check.
  initial begin : result_sink
    int unsigned gap;
    int unsigned taken;
    bit          steady;
    bit          held;
    fsr_result_t want_r;
    taken        = 0;
    steady       = 1'b0;
    held         = 1'b0;
    out_ch.ready = 1'b0;
    gap          = draw_gap(steady);
    forever begin
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      if (due_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind %0h tag %0h handle %0h last %0h",
                 $time, out_ch.event_kind, out_ch.out_tag, out_ch.out_handle,
                 out_ch.last_of_run);
      end else begin
        want_r = due_q.pop_front();
        if (out_ch.event_kind !== want_r.ev.kind)
          flag_mismatch("event_kind", want_r.ev.kind, out_ch.event_kind);
        if (out_ch.out_tag !== want_r.ev.ent.tag)
          flag_mismatch("out_tag", want_r.ev.ent.tag, out_ch.out_tag);
        if (out_ch.out_handle !== want_r.ev.ent.handle)
          flag_mismatch("out_handle", want_r.ev.ent.handle, out_ch.out_handle);
        if (out_ch.last_of_run !== want_r.last)
          flag_mismatch("last_of_run", want_r.last, out_ch.last_of_run);
      end
      taken++;
      // Hold off once while frames are still being offered, so the block backs up.
      if (!held && taken >= HOLD_AFTER && in_ch.valid === 1'b1) begin
        held = 1'b1;
        gap  = HOLD_CYCLES;
      end else begin
        gap = draw_gap(steady);
      end
    end
  end

  // Stimulus: reset, directed table, then random runs at several worker counts.
  initial begin : frame_source
    int unsigned          sent;
    int unsigned          w;
    int unsigned          n;
    int unsigned          pick;
    int unsigned          j;
    int unsigned          t;
    int unsigned          offs [6];
    logic [FSR_TAG_W-1:0] base;
    in_ch.valid        = 1'b0;
    in_ch.frame_tag    = '0;
    in_ch.resequence   = 1'b0;
    in_ch.frame_handle = '0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    rst_n              = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      send_frame(directed_rows[r].tag, directed_rows[r].reseq, directed_rows[r].handle,
                 !directed_rows[r].typed);
      if (directed_rows[r].typed && directed_rows[r].n_typed == 1) begin
        due_q.push_back(fsr_result_t'({directed_rows[r].kind, directed_rows[r].etag,
                                       directed_rows[r].ehandle, 1'b1}));
      end
    end

    foreach (phase_wc[p]) begin
      write_worker_count(phase_wc[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        base = last_seq + 8'd1;
        if (pick < 60) begin
          // Shuffled window of consecutive tags from the expected one, a few duplicated.
          w = $urandom_range(1, 6);
          for (int i = 0; i < w; i++) offs[i] = i;
          for (int i = w - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = offs[i];
            offs[i] = offs[j];
            offs[j] = t;
          end
          for (int i = 0; i < w; i++) begin
            j = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w - 1) : i;
            send_frame(8'(base + offs[j]), 1'b0, 16'($urandom_range(0, 65535)), 1'b1);
          end
          sent += w;
        end else if (pick < 72) begin
          // Resequence to an arbitrary tag.
          send_frame(8'($urandom_range(0, 255)), 1'b1, 16'($urandom_range(0, 65535)), 1'b1);
          sent++;
        end else if (pick < 87) begin
          // Stray frame with an arbitrary tag.
          send_frame(8'($urandom_range(0, 255)), 1'b0, 16'($urandom_range(0, 65535)), 1'b1);
          sent++;
        end else begin
          // Flood of out-of-sequence frames that runs into the pending limit.
          n = $urandom_range(int'(worker_limit) + 2, 17);
          for (int i = 0; i < n; i++) begin
            send_frame(8'(base + 8'($urandom_range(1, 255))), 1'b0,
                       16'($urandom_range(0, 65535)), 1'b1);
          end
          sent += n;
        end
      end
    end

    wait_drained();
    if (errors == 0 && due_q.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Run limit.
  initial begin : run_limit
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
